// ===== hdl/clebuf_pkg.sv =====
package clebuf_pkg;

   localparam int REQ_W  = 3;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 12;
   localparam int STAT_W = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_LEFT   = 3'd0,
      REQ_RIGHT  = 3'd1,
      REQ_BACK   = 3'd2,
      REQ_INSERT = 3'd3,
      REQ_READ   = 3'd4
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE = 2'd0,
      ST_EDGE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_WAIT = 1'b1
   } state_type;

   // Per-transaction control decoded from the command and the gap counts
   typedef struct packed {
      logic       mem_read;   // one RAM read now, result in the next cycle
      logic       mem_write;  // insert: write char_in now
      logic       move;       // write the read byte across the gap
      logic       read_op;    // return the read byte as char_out
      status_type status;
   } plan_type;

endpackage

// ===== hdl/clebuf_if.sv =====
interface clebuf_req_if;
   logic                         valid;
   logic                         ready;
   logic [clebuf_pkg::REQ_W-1:0]  req_type;
   logic [clebuf_pkg::CHAR_W-1:0] char_in;
   logic [clebuf_pkg::IDX_W-1:0]  read_index;

   modport source (output valid, output req_type, output char_in, output read_index,
                   input ready);
   modport sink   (input valid, input req_type, input char_in, input read_index,
                   output ready);
endinterface

interface clebuf_rsp_if #(parameter int COUNT_W = 13);
   logic                          valid;
   logic                          ready;
   logic [clebuf_pkg::CHAR_W-1:0]  char_out;
   logic [COUNT_W-1:0]             text_length;
   logic [COUNT_W-1:0]             cursor_pos;
   logic [clebuf_pkg::STAT_W-1:0]  status;

   modport source (output valid, output char_out, output text_length,
                   output cursor_pos, output status, input ready);
   modport sink   (input valid, input char_out, input text_length,
                   input cursor_pos, input status, output ready);
endinterface

// ===== hdl/clebuf_ram.sv =====
module clebuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/clebuf_plan.sv =====
module clebuf_plan #(
   parameter int CAPACITY = 4096,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic [clebuf_pkg::REQ_W-1:0] req_type,
   input  logic [clebuf_pkg::IDX_W-1:0] read_index,
   input  logic [CW-1:0]                left_cnt,
   input  logic [CW-1:0]                right_cnt,
   output clebuf_pkg::plan_type         plan,
   output logic [AW-1:0]                mem_addr,
   output logic [AW-1:0]                move_addr,
   output logic [CW-1:0]                left_in,
   output logic [CW-1:0]                right_in
);

   localparam int XW = ((CW > clebuf_pkg::IDX_W) ? CW : clebuf_pkg::IDX_W) + 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [CW-1:0] left_dec;
   logic [CW-1:0] right_top;      // lowest address of the right-hand run
   logic [CW-1:0] right_top_dec;  // next free slot below the right-hand run
   logic [CW-1:0] total;
   logic [XW-1:0] idx_x;
   logic [XW-1:0] total_x;
   logic [XW-1:0] left_x;
   logic [XW-1:0] upper_addr;

   assign left_dec      = left_cnt - CW'(1);
   assign right_top     = CAP_C - right_cnt;
   assign right_top_dec = right_top - CW'(1);
   assign total         = left_cnt + right_cnt;
   assign idx_x         = XW'(read_index);
   assign total_x       = XW'(total);
   assign left_x        = XW'(left_cnt);
   assign upper_addr    = XW'(right_top) + idx_x - left_x;

   always_comb begin
      plan.mem_read  = 1'b0;
      plan.mem_write = 1'b0;
      plan.move      = 1'b0;
      plan.read_op   = 1'b0;
      plan.status    = clebuf_pkg::ST_DONE;
      mem_addr       = left_cnt[AW-1:0];
      move_addr      = left_cnt[AW-1:0];
      left_in        = left_cnt;
      right_in       = right_cnt;
      case (clebuf_pkg::req_code_type'(req_type))
         clebuf_pkg::REQ_LEFT: begin
            if (left_cnt == '0) begin
               plan.status = clebuf_pkg::ST_EDGE;
            end else begin
               plan.mem_read = 1'b1;
               plan.move     = 1'b1;
               mem_addr      = left_dec[AW-1:0];
               move_addr     = right_top_dec[AW-1:0];
               left_in       = left_dec;
               right_in      = right_cnt + CW'(1);
            end
         end
         clebuf_pkg::REQ_RIGHT: begin
            if (right_cnt == '0) begin
               plan.status = clebuf_pkg::ST_EDGE;
            end else begin
               plan.mem_read = 1'b1;
               plan.move     = 1'b1;
               mem_addr      = right_top[AW-1:0];
               move_addr     = left_cnt[AW-1:0];
               left_in       = left_cnt + CW'(1);
               right_in      = right_cnt - CW'(1);
            end
         end
         clebuf_pkg::REQ_BACK: begin
            if (left_cnt == '0) begin
               plan.status = clebuf_pkg::ST_EDGE;
            end else begin
               left_in = left_dec;
            end
         end
         clebuf_pkg::REQ_INSERT: begin
            if (total >= CAP_C) begin
               plan.status = clebuf_pkg::ST_FULL;
            end else begin
               plan.mem_write = 1'b1;
               left_in        = left_cnt + CW'(1);
            end
         end
         clebuf_pkg::REQ_READ: begin
            if (idx_x >= total_x) begin
               plan.status = clebuf_pkg::ST_FULL;
            end else begin
               plan.mem_read = 1'b1;
               plan.read_op  = 1'b1;
               if (idx_x < left_x) begin
                  mem_addr = idx_x[AW-1:0];
               end else begin
                  mem_addr = upper_addr[AW-1:0];
               end
            end
         end
         default: begin
            plan.status = clebuf_pkg::ST_DONE;
         end
      endcase
   end

endmodule

// ===== hdl/clebuf_seq.sv =====
module clebuf_seq #(
   parameter int CAPACITY = 4096,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [clebuf_pkg::CHAR_W-1:0] req_char,
   // decoded plan
   input  clebuf_pkg::plan_type          plan,
   input  logic [AW-1:0]                 plan_mem_addr,
   input  logic [AW-1:0]                 plan_move_addr,
   input  logic [CW-1:0]                 plan_left,
   input  logic [CW-1:0]                 plan_right,
   output logic [CW-1:0]                 left_cnt,
   output logic [CW-1:0]                 right_cnt,
   // RAM port
   output logic                          mem_en,
   output logic                          mem_we,
   output logic [AW-1:0]                 mem_addr,
   output logic [clebuf_pkg::CHAR_W-1:0] mem_wdata,
   input  logic [clebuf_pkg::CHAR_W-1:0] mem_rdata,
   // response side
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [clebuf_pkg::CHAR_W-1:0] rsp_char,
   output logic [CW-1:0]                 rsp_length,
   output logic [CW-1:0]                 rsp_cursor,
   output logic [clebuf_pkg::STAT_W-1:0] rsp_status
);

   clebuf_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 left_ff, left_in;
   logic [CW-1:0]                 right_ff, right_in;
   logic [AW-1:0]                 move_addr_ff;
   logic                          move_ff;
   logic                          read_op_ff;
   clebuf_pkg::status_type        status_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clebuf_pkg::CHAR_W-1:0] rsp_char_ff;
   logic [CW-1:0]                 rsp_length_ff;
   logic [CW-1:0]                 rsp_cursor_ff;
   logic [clebuf_pkg::STAT_W-1:0] rsp_status_ff;

   logic accept;
   logic load_now;
   logic load_late;

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clebuf_pkg::S_IDLE: begin
            if (accept && plan.mem_read) begin
               state_in = clebuf_pkg::S_WAIT;
            end
         end
         clebuf_pkg::S_WAIT: begin
            state_in = clebuf_pkg::S_IDLE;
         end
         default: begin
            state_in = clebuf_pkg::S_IDLE;
         end
      endcase
   end

   // outputs: RAM port, handshake, response load
   always_comb begin
      req_ready = 1'b0;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = plan_mem_addr;
      mem_wdata = req_char;
      load_now  = 1'b0;
      load_late = 1'b0;
      case (state_ff)
         clebuf_pkg::S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            mem_en    = accept && (plan.mem_read || plan.mem_write);
            mem_we    = accept && plan.mem_write;
            load_now  = accept && !plan.mem_read;
         end
         clebuf_pkg::S_WAIT: begin
            // write the byte just read across the gap
            mem_en    = move_ff;
            mem_we    = move_ff;
            mem_addr  = move_addr_ff;
            mem_wdata = mem_rdata;
            load_late = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign left_in  = accept ? plan_left  : left_ff;
   assign right_in = accept ? plan_right : right_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_now || load_late) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clebuf_pkg::S_IDLE;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         move_addr_ff <= plan_move_addr;
         move_ff      <= plan.move;
         read_op_ff   <= plan.read_op;
         status_ff    <= plan.status;
      end
      if (load_now) begin
         rsp_char_ff   <= '0;
         rsp_length_ff <= plan_left + plan_right;
         rsp_cursor_ff <= plan_left;
         rsp_status_ff <= plan.status;
      end else if (load_late) begin
         rsp_char_ff   <= read_op_ff ? mem_rdata : '0;
         rsp_length_ff <= left_ff + right_ff;
         rsp_cursor_ff <= left_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign left_cnt   = left_ff;
   assign right_cnt  = right_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_cursor = rsp_cursor_ff;
   assign rsp_status = rsp_status_ff;

   // the response slot is free whenever a read is in flight
   a_wait_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == clebuf_pkg::S_WAIT |-> !rsp_valid_ff)
      else $error("response slot busy while a RAM read is in flight");

   a_wait_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == clebuf_pkg::S_WAIT |=> state_ff == clebuf_pkg::S_IDLE)
      else $error("read wait lasted more than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (left_ff + right_ff) <= CW'(CAPACITY) && left_ff <= CW'(CAPACITY))
      else $error("gap counts exceed capacity");

   a_short_result: assert property (@(posedge clock) disable iff (reset)
      accept && !plan.mem_read |=> rsp_valid_ff)
      else $error("single-cycle transaction produced no response");

endmodule

// ===== hdl/cursor_line_edit_buffer.sv =====
// Channel  Role    Payload                                          Accepted when
// req_if   sink    req_type[2:0] char_in[7:0] read_index[11:0]      valid && ready
// rsp_if   source  char_out[7:0] text_length cursor_pos status[1:0] valid && ready
//
// Backspace, insert, boundary and out-of-range cases, and unknown commands load
// the response without a RAM read; cursor moves and in-range reads wait on the
// registered read of the single-port text RAM, and cursor moves then write back.
// Reset clears the gap counts and the response slot; the text RAM is not cleared.
// req_if.ready drops while a response waits untaken and during the RAM read cycle.
module cursor_line_edit_buffer #(
   parameter int CAPACITY = 4096
) (
   input  logic          clock,
   input  logic          reset,
   clebuf_req_if.sink    req_if,
   clebuf_rsp_if.source  rsp_if
);

   // address into the text store, and width of a count that can reach CAPACITY
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   clebuf_pkg::plan_type          plan;
   logic [AW-1:0]                 plan_mem_addr;
   logic [AW-1:0]                 plan_move_addr;
   logic [CW-1:0]                 plan_left;
   logic [CW-1:0]                 plan_right;
   logic [CW-1:0]                 left_cnt;
   logic [CW-1:0]                 right_cnt;

   logic                          mem_en;
   logic                          mem_we;
   logic [AW-1:0]                 mem_addr;
   logic [clebuf_pkg::CHAR_W-1:0] mem_wdata;
   logic [clebuf_pkg::CHAR_W-1:0] mem_rdata;

   // Decode the command against the current gap: boundary checks, the address
   // to read or insert at, the address across the gap and the new counts.
   clebuf_plan #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_plan (
      .req_type   (req_if.req_type),
      .read_index (req_if.read_index),
      .left_cnt   (left_cnt),
      .right_cnt  (right_cnt),
      .plan       (plan),
      .mem_addr   (plan_mem_addr),
      .move_addr  (plan_move_addr),
      .left_in    (plan_left),
      .right_in   (plan_right)
   );

   // Hold the gap counts, sequence the RAM read and write-back, and register
   // the response so the next transaction can start while it is taken.
   clebuf_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_char       (req_if.char_in),
      .plan           (plan),
      .plan_mem_addr  (plan_mem_addr),
      .plan_move_addr (plan_move_addr),
      .plan_left      (plan_left),
      .plan_right     (plan_right),
      .left_cnt       (left_cnt),
      .right_cnt      (right_cnt),
      .mem_en         (mem_en),
      .mem_we         (mem_we),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .mem_rdata      (mem_rdata),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_char       (rsp_if.char_out),
      .rsp_length     (rsp_if.text_length),
      .rsp_cursor     (rsp_if.cursor_pos),
      .rsp_status     (rsp_if.status)
   );

   // Text store: text left of the cursor at the bottom, right of it at the top.
   clebuf_ram #(
      .WIDTH (clebuf_pkg::CHAR_W),
      .DEPTH (CAPACITY)
   ) u_text_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule
